FILE: design/mmcs_pkg.sv
// shared constants, types and state codes of the mixing model chi-square unit
package mmcs_pkg;

  localparam int MAX_ENDMEMBERS = 8;
  localparam int IDX_W = (MAX_ENDMEMBERS > 1) ? $clog2(MAX_ENDMEMBERS) : 1;
  localparam int DVD_W = 112;
  localparam int CNT_W = 7;

  localparam logic [47:0] CAP48   = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] ONE_Q16 = 48'd65536;

  typedef struct packed {
    logic [47:0] weight;
    logic [47:0] num_prod;
    logic [31:0] em_error;
    logic [31:0] obs_ratio;
    logic [31:0] obs_error;
    logic        last_em;
    logic        last_rt;
  } mmcs_entry_t;

  typedef enum logic {
    CAP_TOTAL,
    CAP_ONE
  } mmcs_cap_t;

  typedef struct packed {
    logic      start;
    mmcs_cap_t cap;
  } mmcs_div_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ZCHK,
    ST_MDIV,
    ST_SERR,
    ST_VINIT,
    ST_PSTART,
    ST_PDIV,
    ST_PEMUL,
    ST_PESQ,
    ST_PACC,
    ST_VCHK,
    ST_SQ_LL,
    ST_SQ_LH,
    ST_SQ_HH,
    ST_SQ_ADD,
    ST_TSTART,
    ST_TDIV,
    ST_ACC,
    ST_EMIT
  } mmcs_state_t;

endpackage

FILE: design/mmcs_front.sv
// front end: takes input beats, clamps the fraction and forms both products
module mmcs_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [16:0]           in_endmember_fraction,
  input  logic [31:0]           in_numerator_conc,
  input  logic [31:0]           in_denominator_conc,
  input  logic [31:0]           in_endmember_error,
  input  logic [31:0]           in_observed_ratio,
  input  logic [31:0]           in_observed_error,
  input  logic                  in_last_endmember,
  input  logic                  in_last_ratio,
  input  logic                  fifo_full,
  output logic                  push,
  output mmcs_pkg::mmcs_entry_t entry
);

  logic [16:0] frac;
  logic [48:0] wprod;
  logic [48:0] nprod;

  always_comb begin
    frac  = (in_endmember_fraction > 17'd65536) ? 17'd65536 : in_endmember_fraction;
    wprod = 49'(frac) * 49'(in_denominator_conc);
    nprod = 49'(frac) * 49'(in_numerator_conc);
    entry.weight    = wprod[47:0];
    entry.num_prod  = nprod[47:0];
    entry.em_error  = in_endmember_error;
    entry.obs_ratio = in_observed_ratio;
    entry.obs_error = in_observed_error;
    entry.last_em   = in_last_endmember;
    entry.last_rt   = in_last_ratio;
  end

  assign in_ready = !fifo_full;
  assign push     = in_valid && !fifo_full;

endmodule

FILE: design/mmcs_fifo.sv
// two-entry queue between front and back end
module mmcs_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mmcs_pkg::mmcs_entry_t wr_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output mmcs_pkg::mmcs_entry_t rd_data
);

  mmcs_pkg::mmcs_entry_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rd_data   = mem_r[rp_r];

endmodule

FILE: design/mmcs_div.sv
// shared restoring divider, one quotient bit per cycle, saturating result
module mmcs_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mmcs_pkg::mmcs_div_ctl_t        ctl,
  input  logic [mmcs_pkg::DVD_W-1:0]     dividend,
  input  logic [63:0]                    divisor,
  output logic                           done,
  output logic [47:0]                    quotient
);

  logic                       busy_r, done_r;
  logic [mmcs_pkg::CNT_W-1:0] cnt_r;
  logic [63:0]                rem_r, den_r;
  logic [mmcs_pkg::DVD_W-1:0] dvd_r;
  logic [48:0]                q_r;
  logic                       ovf_r;
  mmcs_pkg::mmcs_cap_t        cap_r;
  logic [64:0]                sh, dif;
  logic                       ge;
  logic [47:0]                capv;

  always_comb begin
    sh   = {rem_r, dvd_r[mmcs_pkg::DVD_W-1]};
    dif  = sh - {1'b0, den_r};
    ge   = (sh >= {1'b0, den_r});
    capv = (cap_r == mmcs_pkg::CAP_ONE) ? mmcs_pkg::ONE_Q16 : mmcs_pkg::CAP48;
    quotient = (ovf_r || (q_r > {1'b0, capv})) ? capv : q_r[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= mmcs_pkg::CNT_W'(mmcs_pkg::DVD_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      den_r <= divisor;
      dvd_r <= dividend;
      q_r   <= '0;
      ovf_r <= 1'b0;
      cap_r <= ctl.cap;
    end else if (busy_r) begin
      rem_r <= ge ? dif[63:0] : sh[63:0];
      dvd_r <= {dvd_r[mmcs_pkg::DVD_W-2:0], 1'b0};
      q_r   <= {q_r[47:0], ge};
      ovf_r <= ovf_r | q_r[48];
    end
  end

  assign done = done_r;

endmodule

FILE: design/mmcs_back.sv
// back end: sums, weight store, variance pass, misfit term and the total
module mmcs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fifo_valid,
  input  mmcs_pkg::mmcs_entry_t          entry,
  output logic                           pop,
  output mmcs_pkg::mmcs_div_ctl_t        div_ctl,
  output logic [mmcs_pkg::DVD_W-1:0]     div_dividend,
  output logic [63:0]                    div_divisor,
  input  logic                           div_done,
  input  logic [47:0]                    div_quo,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [47:0]                    out_chi_square,
  output logic                           out_zero_divide_fault
);

  localparam int IW = mmcs_pkg::IDX_W;
  localparam logic [IW-1:0] IDX_LAST = IW'(mmcs_pkg::MAX_ENDMEMBERS - 1);

  mmcs_pkg::mmcs_state_t state_r, state_nxt;

  logic [47:0] wmem_r [mmcs_pkg::MAX_ENDMEMBERS];
  logic [31:0] emem_r [mmcs_pkg::MAX_ENDMEMBERS];
  logic        mem_we;

  logic [63:0] nsum_r, nsum_nxt, wsum_r, wsum_nxt, var_r, var_nxt, mul_r;
  logic [IW-1:0] idx_r, idx_nxt, n_r, n_nxt, j_r, j_nxt;
  logic [31:0] obs_r, obs_nxt, serr_r, serr_nxt;
  logic [47:0] diff_r, diff_nxt, term_r, term_nxt, total_r, total_nxt;
  logic [16:0] p_r, p_nxt;
  logic [95:0] sq_r, sq_nxt;
  logic        flt_r, flt_nxt, lastrt_r, lastrt_nxt, fault_r, fault_nxt;
  logic        ov_r, ov_nxt, of_r, of_nxt;
  logic [47:0] oc_r, oc_nxt;
  logic [31:0] mul_a, mul_b;
  logic [64:0] nadd, wadd, vadd;
  logic [48:0] tadd;

  always_comb begin
    state_nxt  = state_r;
    nsum_nxt   = nsum_r;
    wsum_nxt   = wsum_r;
    var_nxt    = var_r;
    idx_nxt    = idx_r;
    n_nxt      = n_r;
    j_nxt      = j_r;
    obs_nxt    = obs_r;
    serr_nxt   = serr_r;
    diff_nxt   = diff_r;
    term_nxt   = term_r;
    total_nxt  = total_r;
    p_nxt      = p_r;
    sq_nxt     = sq_r;
    flt_nxt    = flt_r;
    lastrt_nxt = lastrt_r;
    fault_nxt  = fault_r;
    ov_nxt     = ov_r;
    of_nxt     = of_r;
    oc_nxt     = oc_r;
    pop        = 1'b0;
    mem_we     = 1'b0;
    div_ctl.start = 1'b0;
    div_ctl.cap   = mmcs_pkg::CAP_TOTAL;
    div_dividend  = mmcs_pkg::DVD_W'({nsum_r, 16'd0});
    div_divisor   = wsum_r;
    mul_a = serr_r;
    mul_b = serr_r;
    nadd = {1'b0, nsum_r} + 65'(entry.num_prod);
    wadd = {1'b0, wsum_r} + 65'(entry.weight);
    vadd = {1'b0, var_r} + {1'b0, mul_r};
    tadd = {1'b0, total_r} + {1'b0, term_r};

    if (ov_r && out_ready) ov_nxt = 1'b0;

    unique case (state_r)
      mmcs_pkg::ST_IDLE: begin
        if (fifo_valid) begin
          pop      = 1'b1;
          mem_we   = 1'b1;
          nsum_nxt = nadd[64] ? '1 : nadd[63:0];
          wsum_nxt = wadd[64] ? '1 : wadd[63:0];
          if (entry.last_em) begin
            n_nxt      = idx_r;
            obs_nxt    = entry.obs_ratio;
            serr_nxt   = entry.obs_error;
            lastrt_nxt = entry.last_rt;
            flt_nxt    = 1'b0;
            j_nxt      = '0;
            state_nxt  = mmcs_pkg::ST_ZCHK;
          end else if (idx_r != IDX_LAST) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      mmcs_pkg::ST_ZCHK: begin
        if (wsum_r == '0) begin
          term_nxt  = mmcs_pkg::CAP48;
          flt_nxt   = 1'b1;
          state_nxt = mmcs_pkg::ST_ACC;
        end else begin
          div_ctl.start = 1'b1;
          state_nxt     = mmcs_pkg::ST_MDIV;
        end
      end
      mmcs_pkg::ST_MDIV: begin
        if (div_done) begin
          diff_nxt  = (div_quo >= 48'(obs_r)) ? div_quo - 48'(obs_r) : 48'(obs_r) - div_quo;
          state_nxt = mmcs_pkg::ST_SERR;
        end
      end
      mmcs_pkg::ST_SERR: begin
        state_nxt = mmcs_pkg::ST_VINIT;
      end
      mmcs_pkg::ST_VINIT: begin
        var_nxt   = mul_r;
        state_nxt = mmcs_pkg::ST_PSTART;
      end
      mmcs_pkg::ST_PSTART: begin
        div_ctl.start = 1'b1;
        div_ctl.cap   = mmcs_pkg::CAP_ONE;
        div_dividend  = mmcs_pkg::DVD_W'({wmem_r[j_r], 16'd0});
        state_nxt     = mmcs_pkg::ST_PDIV;
      end
      mmcs_pkg::ST_PDIV: begin
        if (div_done) begin
          p_nxt     = div_quo[16:0];
          state_nxt = mmcs_pkg::ST_PEMUL;
        end
      end
      mmcs_pkg::ST_PEMUL: begin
        mul_a     = 32'(p_r);
        mul_b     = emem_r[j_r];
        state_nxt = mmcs_pkg::ST_PESQ;
      end
      mmcs_pkg::ST_PESQ: begin
        mul_a     = mul_r[47:16];
        mul_b     = mul_r[47:16];
        state_nxt = mmcs_pkg::ST_PACC;
      end
      mmcs_pkg::ST_PACC: begin
        var_nxt = vadd[64] ? '1 : vadd[63:0];
        if (j_r == n_r) begin
          state_nxt = mmcs_pkg::ST_VCHK;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = mmcs_pkg::ST_PSTART;
        end
      end
      mmcs_pkg::ST_VCHK: begin
        if (var_r == '0) begin
          term_nxt  = mmcs_pkg::CAP48;
          flt_nxt   = 1'b1;
          state_nxt = mmcs_pkg::ST_ACC;
        end else begin
          state_nxt = mmcs_pkg::ST_SQ_LL;
        end
      end
      mmcs_pkg::ST_SQ_LL: begin
        mul_a     = diff_r[31:0];
        mul_b     = diff_r[31:0];
        state_nxt = mmcs_pkg::ST_SQ_LH;
      end
      mmcs_pkg::ST_SQ_LH: begin
        sq_nxt    = 96'(mul_r);
        mul_a     = diff_r[31:0];
        mul_b     = 32'(diff_r[47:32]);
        state_nxt = mmcs_pkg::ST_SQ_HH;
      end
      mmcs_pkg::ST_SQ_HH: begin
        sq_nxt    = sq_r + (96'(mul_r) << 33);
        mul_a     = 32'(diff_r[47:32]);
        mul_b     = 32'(diff_r[47:32]);
        state_nxt = mmcs_pkg::ST_SQ_ADD;
      end
      mmcs_pkg::ST_SQ_ADD: begin
        sq_nxt    = sq_r + {mul_r[31:0], 64'd0};
        state_nxt = mmcs_pkg::ST_TSTART;
      end
      mmcs_pkg::ST_TSTART: begin
        div_ctl.start = 1'b1;
        div_dividend  = {sq_r, 16'd0};
        div_divisor   = var_r;
        state_nxt     = mmcs_pkg::ST_TDIV;
      end
      mmcs_pkg::ST_TDIV: begin
        if (div_done) begin
          term_nxt  = div_quo;
          state_nxt = mmcs_pkg::ST_ACC;
        end
      end
      mmcs_pkg::ST_ACC: begin
        total_nxt = tadd[48] ? mmcs_pkg::CAP48 : tadd[47:0];
        fault_nxt = fault_r | flt_r;
        nsum_nxt  = '0;
        wsum_nxt  = '0;
        idx_nxt   = '0;
        state_nxt = lastrt_r ? mmcs_pkg::ST_EMIT : mmcs_pkg::ST_IDLE;
      end
      mmcs_pkg::ST_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          oc_nxt    = total_r;
          of_nxt    = fault_r;
          total_nxt = '0;
          fault_nxt = 1'b0;
          state_nxt = mmcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mmcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmcs_pkg::ST_IDLE;
      nsum_r  <= '0;
      wsum_r  <= '0;
      idx_r   <= '0;
      total_r <= '0;
      fault_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nsum_r  <= nsum_nxt;
      wsum_r  <= wsum_nxt;
      idx_r   <= idx_nxt;
      total_r <= total_nxt;
      fault_r <= fault_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    var_r    <= var_nxt;
    n_r      <= n_nxt;
    j_r      <= j_nxt;
    obs_r    <= obs_nxt;
    serr_r   <= serr_nxt;
    diff_r   <= diff_nxt;
    term_r   <= term_nxt;
    p_r      <= p_nxt;
    sq_r     <= sq_nxt;
    flt_r    <= flt_nxt;
    lastrt_r <= lastrt_nxt;
    of_r     <= of_nxt;
    oc_r     <= oc_nxt;
    mul_r    <= 64'(mul_a) * 64'(mul_b);
    if (mem_we) begin
      wmem_r[idx_r] <= entry.weight;
      emem_r[idx_r] <= entry.em_error;
    end
  end

  assign out_valid             = ov_r;
  assign out_chi_square        = oc_r;
  assign out_zero_divide_fault = of_r;

endmodule

FILE: design/mixing_model_chi_square_unit.sv
// top level of the mixing model chi-square unit
// an endmember beat that does not close a ratio leaves the queue once the back end is idle
// a closing beat is paced by the shared divider, 112 steps per division (model ratio,
// one fraction per endmember, term)
// a two-entry queue lets the front take beats while the back end is busy
// reset: synchronous active-low, clears sums, index, total, fault and valid
module mixing_model_chi_square_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [16:0] in_endmember_fraction,
  input  logic [31:0] in_numerator_conc,
  input  logic [31:0] in_denominator_conc,
  input  logic [31:0] in_endmember_error,
  input  logic [31:0] in_observed_ratio,
  input  logic [31:0] in_observed_error,
  input  logic        in_last_endmember,
  input  logic        in_last_ratio,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_chi_square,
  output logic        out_zero_divide_fault
);

  mmcs_pkg::mmcs_entry_t   wr_entry, rd_entry;
  mmcs_pkg::mmcs_div_ctl_t div_ctl;
  logic                    push, pop, full, not_empty, div_done;
  logic [mmcs_pkg::DVD_W-1:0] div_dividend;
  logic [63:0]             div_divisor;
  logic [47:0]             div_quo;

  mmcs_front u_front (
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_endmember_fraction (in_endmember_fraction),
    .in_numerator_conc     (in_numerator_conc),
    .in_denominator_conc   (in_denominator_conc),
    .in_endmember_error    (in_endmember_error),
    .in_observed_ratio     (in_observed_ratio),
    .in_observed_error     (in_observed_error),
    .in_last_endmember     (in_last_endmember),
    .in_last_ratio         (in_last_ratio),
    .fifo_full             (full),
    .push                  (push),
    .entry                 (wr_entry)
  );

  mmcs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (wr_entry),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .rd_data   (rd_entry)
  );

  mmcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  mmcs_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .fifo_valid            (not_empty),
    .entry                 (rd_entry),
    .pop                   (pop),
    .div_ctl               (div_ctl),
    .div_dividend          (div_dividend),
    .div_divisor           (div_divisor),
    .div_done              (div_done),
    .div_quo               (div_quo),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_chi_square        (out_chi_square),
    .out_zero_divide_fault (out_zero_divide_fault)
  );

endmodule

FILE: design/mmcs_checker.sv
// port-level checker for the mixing model chi-square unit and its bind
module mmcs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_endmember,
  input logic        in_last_ratio,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_chi_square,
  input logic        out_zero_divide_fault
);

  logic [3:0] pend_r;
  logic       in_close, out_take;

  assign in_close = in_valid && in_ready && in_last_endmember && in_last_ratio;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {3'd0, in_close} - {3'd0, out_take};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_chi_square) && $stable(out_zero_divide_fault))
    else $error("stalled result beat changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without a closing input beat");

endmodule

bind mixing_model_chi_square_unit mmcs_checker u_mmcs_checker (.*);
